>>> rtl/max_priority_task_queue_defines.svh
// ---------------------------------------------------------------------------
// max_priority_task_queue_defines
// Assertion macros used by the task queue datapath.
// ---------------------------------------------------------------------------
`ifndef MAX_PRIORITY_TASK_QUEUE_DEFINES_SVH
`define MAX_PRIORITY_TASK_QUEUE_DEFINES_SVH

// same-cycle implication
`define MPQ_ASSERT_HOLD(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/mpq_pkg.sv
// ---------------------------------------------------------------------------
// mpq_pkg
// Types and constants shared by the task queue controller and datapath.
// ---------------------------------------------------------------------------
package mpq_pkg;

   localparam int DEPTH_DEFAULT = 8;

   localparam int TASK_W      = 16;
   localparam int PRIO_W      = 16;
   localparam int OCC_W       = 4;
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 3;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } mpq_status_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [TASK_W-1:0] task_num;
   } mpq_entry_type;

   // controller -> datapath
   typedef struct packed {
      logic           capture;
      logic           write_new;
      logic           scan_init;
      logic           scan_read;
      logic           shift_init;
      logic           shift_read;
      logic           pop;
      logic           post;
      logic           served;
      mpq_status_type code;
   } mpq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic remove;
      logic full;
      logic empty;
      logic scan_done;
      logic rd_busy;
   } mpq_stat_type;

endpackage

>>> rtl/mpq_datapath.sv
// ---------------------------------------------------------------------------
// mpq_datapath
// Entry memory, fill count, max-priority scan and shift-down logic.
// ---------------------------------------------------------------------------
`include "max_priority_task_queue_defines.svh"

module mpq_datapath import mpq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  mpq_cmd_type       cmd,
   output mpq_stat_type      stat,
   input  logic              in_action,
   input  logic [TASK_W-1:0] in_task,
   input  logic [PRIO_W-1:0] in_prio,
   output logic [TASK_W-1:0] out_served_task,
   output logic              out_served_valid,
   output logic [1:0]        out_status,
   output logic [OCC_W-1:0]  out_occupancy
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      RD_NONE,
      RD_SCAN,
      RD_SHIFT
   } rd_kind_type;

   mpq_entry_type entry_mem [DEPTH];

   logic              action_ff, action_in;
   logic [TASK_W-1:0] task_ff, task_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  ridx_ff, ridx_in;
   rd_kind_type       rd_kind_ff, rd_kind_in;
   mpq_entry_type     rdata_ff;
   logic              first_ff, first_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic [TASK_W-1:0] best_task_ff, best_task_in;

   logic [TASK_W-1:0] served_task_ff, served_task_in;
   logic              served_valid_ff, served_valid_in;
   mpq_status_type    status_ff, status_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   mpq_entry_type     wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;

   // memory port: one write, one registered read
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = '{prio: prio_ff, task_num: task_ff};
      if (cmd.write_new) begin
         wr_en = 1'b1;
      end else if (rd_kind_ff == RD_SHIFT) begin
         // entry read at ridx moves down one place
         wr_en   = 1'b1;
         wr_addr = ridx_ff - 1'b1;
         wr_data = rdata_ff;
      end
      rd_en   = cmd.scan_read | cmd.shift_read;
      rd_addr = idx_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= entry_mem[rd_addr];
      end
   end

   always_comb begin
      action_in       = action_ff;
      task_in         = task_ff;
      prio_in         = prio_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      ridx_in         = idx_ff[IDX_W-1:0];
      rd_kind_in      = RD_NONE;
      first_in        = first_ff;
      best_idx_in     = best_idx_ff;
      best_prio_in    = best_prio_ff;
      best_task_in    = best_task_ff;
      served_task_in  = served_task_ff;
      served_valid_in = served_valid_ff;
      status_in       = status_ff;
      occ_in          = occ_ff;

      if (cmd.capture) begin
         action_in = in_action;
         task_in   = in_task;
         prio_in   = in_prio;
      end

      if (cmd.write_new) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end

      if (cmd.scan_init) begin
         idx_in   = '0;
         first_in = 1'b1;
      end else if (cmd.shift_init) begin
         idx_in = CNT_W'(best_idx_ff) + 1'b1;
      end else if (cmd.scan_read || cmd.shift_read) begin
         idx_in = idx_ff + 1'b1;
      end

      if (cmd.scan_read) begin
         rd_kind_in = RD_SCAN;
      end else if (cmd.shift_read) begin
         rd_kind_in = RD_SHIFT;
      end

      // strict compare keeps the oldest entry on a tie
      if (rd_kind_ff == RD_SCAN && (first_ff || rdata_ff.prio > best_prio_ff)) begin
         first_in     = 1'b0;
         best_idx_in  = ridx_ff;
         best_prio_in = rdata_ff.prio;
         best_task_in = rdata_ff.task_num;
      end

      if (cmd.post) begin
         served_task_in  = cmd.served ? best_task_ff : '0;
         served_valid_in = cmd.served;
         status_in       = cmd.code;
         occ_in          = OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rd_kind_ff <= RD_NONE;
      end else begin
         count_ff   <= count_in;
         rd_kind_ff <= rd_kind_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff       <= action_in;
      task_ff         <= task_in;
      prio_ff         <= prio_in;
      idx_ff          <= idx_in;
      ridx_ff         <= ridx_in;
      first_ff        <= first_in;
      best_idx_ff     <= best_idx_in;
      best_prio_ff    <= best_prio_in;
      best_task_ff    <= best_task_in;
      served_task_ff  <= served_task_in;
      served_valid_ff <= served_valid_in;
      status_ff       <= status_in;
      occ_ff          <= occ_in;
   end

   assign stat.remove    = action_ff;
   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.empty     = (count_ff == '0);
   assign stat.scan_done = (idx_ff == count_ff);
   assign stat.rd_busy   = (rd_kind_ff != RD_NONE);

   assign out_served_task  = served_task_ff;
   assign out_served_valid = served_valid_ff;
   assign out_status       = status_ff;
   assign out_occupancy    = occ_ff;

   `MPQ_ASSERT_HOLD(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "count above depth")
   `MPQ_ASSERT_HOLD(a_no_write_full, clock, reset, cmd.write_new, !stat.full, "insert into full store")
   `MPQ_ASSERT_NEXT(a_pop_count, clock, reset, cmd.pop, count_ff == $past(count_ff) - 1'b1, "pop did not drop count")
   `MPQ_ASSERT_HOLD(a_read_range, clock, reset, cmd.scan_read || cmd.shift_read, idx_ff < count_ff, "read past last entry")

endmodule

>>> rtl/mpq_ctrl.sv
// ---------------------------------------------------------------------------
// mpq_ctrl
// Sequencer for insert, scan and shift phases plus the stream handshakes.
// ---------------------------------------------------------------------------
module mpq_ctrl import mpq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output mpq_cmd_type  cmd,
   input  mpq_stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_SHIFT,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      valid_ff, valid_in;

   always_comb begin
      cmd      = '0;
      cmd.code = ST_OK;
      state_in = state_ff;
      ready_in = ready_ff;
      valid_in = valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.capture = 1'b1;
               ready_in    = 1'b0;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!stat.remove) begin
               cmd.post = 1'b1;
               if (stat.full) begin
                  cmd.code = ST_FULL;
               end else begin
                  cmd.write_new = 1'b1;
               end
               valid_in = 1'b1;
               state_in = S_RESP;
            end else if (stat.empty) begin
               cmd.post = 1'b1;
               cmd.code = ST_EMPTY;
               valid_in = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!stat.scan_done) begin
               cmd.scan_read = 1'b1;
            end else if (!stat.rd_busy) begin
               cmd.shift_init = 1'b1;
               state_in       = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (!stat.scan_done) begin
               cmd.shift_read = 1'b1;
            end else if (!stat.rd_busy) begin
               cmd.pop    = 1'b1;
               cmd.post   = 1'b1;
               cmd.served = 1'b1;
               valid_in   = 1'b1;
               state_in   = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_tready && valid_ff) begin
               valid_in = 1'b0;
               ready_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            valid_in = 1'b0;
            ready_in = 1'b1;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = valid_ff;

endmodule

>>> rtl/max_priority_task_queue.sv
// ---------------------------------------------------------------------------
// max_priority_task_queue
// Fixed-depth task store with insert and remove-highest-priority.
// ---------------------------------------------------------------------------
// Each request word is an insert or a remove and returns exactly one response
// word; one request is handled at a time. An insert, and any refused request,
// is answered straight from the execute state, with no scan. A remove reads
// every stored entry once through the single read port of the entry memory to
// find the highest priority (oldest wins a tie), then reads the entries behind
// the winner again and writes them one place down. The request side reopens
// the cycle after the response word is taken, so a new request word is taken
// only once the response to the last one has been taken. Inserting into a full
// store or removing from an empty one answers with an error status and changes
// nothing. Entries below the fill count are the only ones ever read.
module max_priority_task_queue import mpq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [15:0] task_number, [31:16] priority_req
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] action
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [15:0] served_task, [19:16] occupancy, [23:20] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [0] served_valid, [2:1] status
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   mpq_cmd_type       cmd;
   mpq_stat_type      stat;
   logic [TASK_W-1:0] served_task;
   logic              served_valid;
   logic [1:0]        status;
   logic [OCC_W-1:0]  occupancy;

   mpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   mpq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .in_action        (req_tuser[0]),
      .in_task          (req_tdata[TASK_W-1:0]),
      .in_prio          (req_tdata[TASK_W+PRIO_W-1:TASK_W]),
      .out_served_task  (served_task),
      .out_served_valid (served_valid),
      .out_status       (status),
      .out_occupancy    (occupancy)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - TASK_W - OCC_W){1'b0}}, occupancy, served_task};
   assign rsp_tuser = {status, served_valid};

endmodule

>>> dv/max_priority_task_queue_tb.sv
// ---------------------------------------------------------------------------
// max_priority_task_queue_tb
// Self-checking bench for the task queue. Request words go in and response
// words come out. A scoreboard model of the entry store predicts each
// response. A short directed pass covers empty, full and tie ordering.
// Biased random traffic then fills and drains the store, with random
// back-pressure on both sides in all but one pass.
// ---------------------------------------------------------------------------
module max_priority_task_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mpq_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int SETTLE      = 2 * DEPTH + 10;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   typedef struct {
      logic [TASK_W-1:0] served_num;
      logic              served_flag;
      logic [1:0]        status;
      logic [OCC_W-1:0]  occ;
   } reply_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   // scoreboard copy of the entry store
   logic [TASK_W-1:0] held_num  [DEPTH];
   logic [PRIO_W-1:0] held_prio [DEPTH];
   int                held_count;

   reply_type pending_replies[$];
   int        fail_count;
   int        cycle_count;
   logic      stall_on;

   max_priority_task_queue #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= stall_on ? ($urandom_range(99) >= 17) : 1'b1;
   end

   // Applies one request to the scoreboard store and returns the reply.
   function automatic reply_type predict_reply(logic act, logic [TASK_W-1:0] num,
                                               logic [PRIO_W-1:0] prio);
      reply_type r;
      int        best;
      r.served_num  = '0;
      r.served_flag = 1'b0;
      r.status      = ST_OK;
      if (act == ACT_INSERT) begin
         if (held_count >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            held_num[held_count]  = num;
            held_prio[held_count] = prio;
            held_count++;
         end
      end else if (held_count == 0) begin
         r.status = ST_EMPTY;
      end else begin
         // strict compare keeps the oldest entry on a tie
         best = 0;
         for (int i = 1; i < held_count; i++)
            if (held_prio[i] > held_prio[best]) best = i;
         r.served_num  = held_num[best];
         r.served_flag = 1'b1;
         for (int i = best; i + 1 < held_count; i++) begin
            held_num[i]  = held_num[i+1];
            held_prio[i] = held_prio[i+1];
         end
         held_count--;
      end
      r.occ = OCC_W'(held_count);
      return r;
   endfunction

   always @(posedge clock) begin : reply_check
      reply_type want;
      reply_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.served_num  = rsp_tdata[15:0];
         got.occ         = rsp_tdata[19:16];
         got.served_flag = rsp_tuser[0];
         got.status      = rsp_tuser[2:1];
         if (pending_replies.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected response word task %h occ %0d", $realtime,
                        got.served_num, got.occ);
         end else begin
            want = pending_replies.pop_front();
            if (got.served_num !== want.served_num || got.served_flag !== want.served_flag ||
                got.status !== want.status || got.occ !== want.occ) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"%0t: mismatch exp task %h vld %b st %0d occ %0d, ",
                            "got task %h vld %b st %0d occ %0d"},
                           $realtime, want.served_num, want.served_flag, want.status,
                           want.occ, got.served_num, got.served_flag, got.status,
                           got.occ);
            end
         end
      end
   end

   // Called just after a falling edge; returns just after a falling edge with
   // tvalid still high, so the next call can follow back to back.
   task automatic send_word(logic act, logic [TASK_W-1:0] num, logic [PRIO_W-1:0] prio);
      while (stall_on && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {prio, num};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_replies.push_back(predict_reply(act, num, prio));
      @(negedge clock);
   endtask

   task automatic wait_replies();
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(negedge clock);
   endtask

   task automatic test_empty_and_full();
      send_word(ACT_REMOVE, 16'hFFFF, 16'hFFFF);
      send_word(ACT_INSERT, 16'hFFFF, 16'hFFFF);
      send_word(ACT_INSERT, 16'h0000, 16'h0000);
      send_word(ACT_INSERT, 16'h1111, 16'h8000);
      send_word(ACT_INSERT, 16'h2222, 16'hFFFF);
      send_word(ACT_INSERT, 16'h3333, 16'h0001);
      send_word(ACT_INSERT, 16'h4444, 16'h8000);
      send_word(ACT_INSERT, 16'h5555, 16'h7FFF);
      send_word(ACT_INSERT, 16'hAAAA, 16'h0000);
      send_word(ACT_INSERT, 16'h5A5A, 16'hA5A5);
   endtask

   // drains the full store: first entry wins, ties go to the older entry
   task automatic test_tie_order();
      repeat (DEPTH + 1) send_word(ACT_REMOVE, 16'h0000, 16'h0000);
   endtask

   task automatic test_last_entry_wins();
      send_word(ACT_INSERT, 16'h0001, 16'h0010);
      send_word(ACT_INSERT, 16'h0002, 16'h0020);
      send_word(ACT_INSERT, 16'h0003, 16'hFFFE);
      repeat (3) send_word(ACT_REMOVE, 16'h0000, 16'h0000);
   endtask

   task automatic test_random_traffic(int words, int insert_pct);
      logic              act;
      logic [TASK_W-1:0] num;
      logic [PRIO_W-1:0] prio;
      repeat (words) begin
         act = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
         num = 16'($urandom_range(16'hFFFF));
         case ($urandom_range(9))
            0, 1, 2, 3: prio = 16'($urandom_range(3));  // narrow range forces ties
            4:          prio = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default:    prio = 16'($urandom_range(16'hFFFF));
         endcase
         send_word(act, num, prio);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      stall_on    = 1'b1;
      held_count  = 0;
      fail_count  = 0;
      cycle_count = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_and_full();
      test_tie_order();
      test_last_entry_wins();

      test_random_traffic(250, 70);
      test_random_traffic(200, 30);
      wait_replies();
      @(negedge clock);
      test_random_traffic(200, 55);
      stall_on = 1'b0;
      test_random_traffic(150, 50);
      stall_on = 1'b1;
      test_random_traffic(150, 45);

      wait_replies();
      repeat (SETTLE) @(negedge clock);
      if (fail_count == 0 && pending_replies.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
